FILE: rtl/asfm_pkg.sv
package asfm_pkg;

    localparam int SYM_W   = 16;
    localparam int COUNT_W = 14;
    localparam int POS_W   = 9;
    localparam int FOUND_W = 10;
    localparam int USED_W  = 9;

    localparam logic [COUNT_W-1:0]        COUNT_MAX  = '1;
    localparam logic signed [FOUND_W-1:0] FOUND_NONE = '1;

    localparam logic REG_ESCAPE = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        MODE_INC     = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_FIND    = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                    mode;
        logic [POS_W-1:0]         entry_position;
        logic signed [SYM_W-1:0]  symbol_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [FOUND_W-1:0] found_position;
        status_t                   status;
        logic [COUNT_W-1:0]        total_now;
        logic [USED_W-1:0]         used_slots;
    } out_beat_t;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic [COUNT_W-1:0] cnt;
    } slot_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

FILE: rtl/adaptive_sorted_frequency_model_core.sv
// Sorted frequency table for an adaptive arithmetic coder, one item at a time. The table
// lives in a single memory with one write and one registered read port, and a small
// sequencer walks it, so the memory port sets the pace of every operation. An increase
// reads the entry, moves it up past every entry above it with a smaller count and writes
// it back; when the total reaches total_limit a halving pass halves every used count,
// rounding up. A find reads the used entries from position 0 up to the first hit. An add
// or an out-of-range increase needs no table walk, and a restart rewrites every slot.
// After reset a clearing pass rebuilds the table while s_ready stays low; configuration
// writes are taken throughout. A finished result waits in the output register, and the
// next item may be accepted meanwhile.
module adaptive_sorted_frequency_model_core #(
    parameter int TABLE_SLOTS = 257
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  asfm_pkg::in_beat_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output asfm_pkg::out_beat_t       m_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import asfm_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] ALL_SLOTS = CNT_W'(TABLE_SLOTS);

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_INC_LD   = 10'b0000000100,
        ST_INC_CMP  = 10'b0000001000,
        ST_INC_WR   = 10'b0000010000,
        ST_HALVE_RD = 10'b0000100000,
        ST_HALVE_WR = 10'b0001000000,
        ST_FIND_RD  = 10'b0010000000,
        ST_FIND_CHK = 10'b0100000000,
        ST_FIN      = 10'b1000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [SYM_W-1:0]          sym_reg, sym_next;
    logic [COUNT_W-1:0]        sum_reg, sum_next;
    logic signed [FOUND_W-1:0] found_reg, found_next;
    status_t                   status_reg, status_next;
    logic [COUNT_W-1:0]        total_reg, total_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic                      reply_reg, reply_next;
    logic [SYM_W-1:0]          escape_reg;
    logic [COUNT_W-1:0]        limit_reg;
    out_beat_t                 out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    slot_t                     slot_mem [TABLE_SLOTS];
    slot_t                     slot_rd_reg;
    logic                      mem_we, mem_re;
    logic [IDX_W-1:0]          mem_waddr, mem_raddr;
    slot_t                     mem_wdata;

    logic                      cfg_write;
    logic [COUNT_W-1:0]        inc_total;
    logic [COUNT_W-1:0]        half_cnt;
    logic [COUNT_W:0]          half_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_LIMIT) ? {{(32 - COUNT_W){1'b0}}, limit_reg}
                                               : {{(32 - SYM_W){1'b0}}, escape_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign inc_total = sat_inc(total_reg);
    assign half_cnt  = COUNT_W'(({1'b0, slot_rd_reg.cnt} + (COUNT_W + 1)'(1)) >> 1);
    assign half_sum  = {1'b0, sum_reg} + {1'b0, half_cnt};

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        sym_next     = sym_reg;
        sum_next     = sum_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        total_next   = total_reg;
        used_next    = used_reg;
        reply_next   = reply_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IDX_W-1:0];
        mem_wdata    = slot_rd_reg;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_wdata.cnt = COUNT_W'(1);
                mem_wdata.sym = (idx_reg == LAST_SLOT) ? escape_reg : SYM_W'(idx_reg);
                if (idx_reg == LAST_SLOT) begin
                    total_next = COUNT_W'(TABLE_SLOTS);
                    used_next  = ALL_SLOTS;
                    state_next = reply_reg ? ST_FIN : ST_IDLE;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    found_next  = FOUND_NONE;
                    status_next = STAT_OK;
                    sym_next    = s_data.symbol_value;
                    idx_next    = '0;
                    case (s_data.mode)
                        MODE_INC: begin
                            if (CMP_W'(s_data.entry_position) >= CMP_W'(used_reg)) begin
                                status_next = STAT_RANGE;
                                state_next  = ST_FIN;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = IDX_W'(s_data.entry_position);
                                idx_next   = CNT_W'(s_data.entry_position);
                                state_next = ST_INC_LD;
                            end
                        end
                        MODE_ADD: begin
                            if (used_reg >= ALL_SLOTS) begin
                                status_next = STAT_FULL;
                            end else begin
                                mem_we        = 1'b1;
                                mem_waddr     = used_reg[IDX_W-1:0];
                                mem_wdata.sym = s_data.symbol_value;
                                mem_wdata.cnt = COUNT_W'(1);
                                used_next     = used_reg + CNT_W'(1);
                                total_next    = inc_total;
                            end
                            state_next = ST_FIN;
                        end
                        MODE_FIND: begin
                            state_next = ST_FIND_RD;
                        end
                        MODE_RESTART: begin
                            reply_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_INC_LD: begin
                cnt_next = sat_inc(slot_rd_reg.cnt);
                sym_next = slot_rd_reg.sym;
                if (idx_reg == '0) begin
                    state_next = ST_INC_WR;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = ST_INC_CMP;
                end
            end
            ST_INC_CMP: begin
                if (slot_rd_reg.cnt < cnt_reg) begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg - CNT_W'(1);
                    if (idx_reg == CNT_W'(1)) begin
                        state_next = ST_INC_WR;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(idx_reg - CNT_W'(2));
                    end
                end else begin
                    state_next = ST_INC_WR;
                end
            end
            ST_INC_WR: begin
                mem_we        = 1'b1;
                mem_wdata.sym = sym_reg;
                mem_wdata.cnt = cnt_reg;
                total_next    = inc_total;
                if (inc_total >= limit_reg) begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_HALVE_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_HALVE_RD: begin
                if (idx_reg < used_reg) begin
                    mem_re     = 1'b1;
                    state_next = ST_HALVE_WR;
                end else begin
                    total_next = sum_reg;
                    state_next = ST_FIN;
                end
            end
            ST_HALVE_WR: begin
                mem_we        = 1'b1;
                mem_wdata.cnt = half_cnt;
                sum_next      = half_sum[COUNT_W] ? COUNT_MAX : half_sum[COUNT_W-1:0];
                idx_next      = idx_reg + CNT_W'(1);
                state_next    = ST_HALVE_RD;
            end
            ST_FIND_RD: begin
                if (idx_reg < used_reg) begin
                    mem_re     = 1'b1;
                    state_next = ST_FIND_CHK;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIND_CHK: begin
                if (slot_rd_reg.sym == sym_reg) begin
                    found_next = FOUND_W'(idx_reg);
                    state_next = ST_FIN;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_FIND_RD;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.found_position = found_reg;
                    out_next.status         = status_reg;
                    out_next.total_now      = total_reg;
                    out_next.used_slots     = USED_W'(used_reg);
                    m_valid_next            = 1'b1;
                    reply_next              = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            slot_rd_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            reply_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            total_reg   <= COUNT_W'(TABLE_SLOTS);
            used_reg    <= ALL_SLOTS;
            escape_reg  <= '1;
            limit_reg   <= COUNT_W'(8192);
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            reply_reg   <= reply_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            used_reg    <= used_next;
            if (cfg_write) begin
                if (paddr[2] == REG_LIMIT) begin
                    limit_reg <= pwdata[COUNT_W-1:0];
                end else begin
                    escape_reg <= pwdata[SYM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        sym_reg    <= sym_next;
        sum_reg    <= sum_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= ALL_SLOTS)
        else $error("Slot count exceeds the table size.");

    a_bubble_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INC_CMP) |-> (idx_reg != '0 && idx_reg < used_reg))
        else $error("Bubble index left the used part of the table.");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second item was taken while one is at work.");

    a_found_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_OK) |-> (m_data.found_position == FOUND_NONE))
        else $error("A failed step reported a found position.");
`endif

endmodule

FILE: sim/adaptive_sorted_frequency_model_core_tb.sv
`timescale 1ns / 100ps

module adaptive_sorted_frequency_model_core_tb;
    import asfm_pkg::*;

    localparam int TABLE_SLOTS  = 257;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 297;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 1000;
    localparam int LIMIT_CYCLES = 6000000;

    localparam logic [SYM_W-1:0] PHASE_ESCAPE [PHASES] =
        '{16'h7FFF, 16'h8000, 16'h0005, 16'h0000, 16'hFFFF, 16'h1234};
    localparam logic [COUNT_W-1:0] PHASE_LIMIT [PHASES] =
        '{14'd1, 14'd16383, 14'd400, 14'd2, 14'd300, 14'd8192};
    localparam int PHASE_SEND_IDLE [PHASES]  = '{0, 56, 0, 10, 0, 56};
    localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 56, 10, 0, 0};

    class sorted_table_tracker;
        logic [SYM_W-1:0]   symbols [TABLE_SLOTS];
        logic [COUNT_W-1:0] counts [TABLE_SLOTS];
        logic [COUNT_W-1:0] total;
        int unsigned        in_use;
        logic [SYM_W-1:0]   escape;
        logic [COUNT_W-1:0] limit;
        out_beat_t          pending_results [$];
        int                 mismatches;

        function new();
            escape     = '1;
            limit      = 14'd8192;
            mismatches = 0;
            rebuild();
        endfunction

        function logic [COUNT_W-1:0] step_count(input logic [COUNT_W-1:0] v);
            return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
        endfunction

        function void rebuild();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                counts[i]  = 1;
                symbols[i] = SYM_W'(i);
            end
            symbols[TABLE_SLOTS-1] = escape;
            total  = (TABLE_SLOTS > COUNT_MAX) ? COUNT_MAX : COUNT_W'(TABLE_SLOTS);
            in_use = TABLE_SLOTS;
        endfunction

        function void halve();
            int sum;
            sum = 0;
            for (int i = 0; i < in_use; i++) begin
                counts[i] = COUNT_W'((15'(counts[i]) + 15'd1) >> 1);
                sum += counts[i];
                if (sum > COUNT_MAX) sum = COUNT_MAX;
            end
            total = COUNT_W'(sum);
        endfunction

        function void bump(input int pos);
            logic [COUNT_W-1:0] c;
            logic [SYM_W-1:0]   s;
            int                 i;
            c = step_count(counts[pos]);
            s = symbols[pos];
            i = pos;
            while (i > 0 && counts[i-1] < c) begin
                counts[i]  = counts[i-1];
                symbols[i] = symbols[i-1];
                i--;
            end
            counts[i]  = c;
            symbols[i] = s;
            total = step_count(total);
            if (total >= limit) halve();
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == REG_ESCAPE) escape = value[SYM_W-1:0];
            else limit = value[COUNT_W-1:0];
        endfunction

        function void take_item(input in_beat_t b);
            out_beat_t r;
            r.found_position = FOUND_NONE;
            r.status         = STAT_OK;
            case (b.mode)
                MODE_INC: begin
                    if (b.entry_position >= in_use) r.status = STAT_RANGE;
                    else bump(int'(b.entry_position));
                end
                MODE_ADD: begin
                    if (in_use >= TABLE_SLOTS) begin
                        r.status = STAT_FULL;
                    end else begin
                        symbols[in_use] = b.symbol_value;
                        counts[in_use]  = 1;
                        in_use++;
                        total = step_count(total);
                    end
                end
                MODE_FIND: begin
                    for (int i = 0; i < in_use; i++) begin
                        if (symbols[i] == b.symbol_value) begin
                            r.found_position = FOUND_W'(i);
                            break;
                        end
                    end
                end
                default: rebuild();
            endcase
            r.total_now  = total;
            r.used_slots = USED_W'(in_use);
            pending_results.push_back(r);
        endfunction

        function void match_result(input out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with none pending: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.found_position !== want.found_position) begin
                $error("found_position: expected %0d, got %0d",
                       want.found_position, got.found_position);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.total_now !== want.total_now) begin
                $error("total_now: expected %0d, got %0d", want.total_now, got.total_now);
                mismatches++;
            end
            if (got.used_slots !== want.used_slots) begin
                $error("used_slots: expected %0d, got %0d", want.used_slots, got.used_slots);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    sorted_table_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int cycles         = 0;

    adaptive_sorted_frequency_model_core #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) tracker.take_item(s_data);
        if (aresetn && m_valid && m_ready) tracker.match_result(m_data);
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input in_beat_t b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer(input mode_t m, input int pos, input int sym);
        in_beat_t b;
        b.mode           = m;
        b.entry_position = pos[POS_W-1:0];
        b.symbol_value   = sym[SYM_W-1:0];
        send_item(b);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic in_beat_t random_item();
        in_beat_t b;
        int       pick;
        int       sub;
        b.entry_position = POS_W'($urandom);
        b.symbol_value   = SYM_W'($urandom);
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (pick < 55) begin
            b.mode = MODE_INC;
            if (sub < 25) b.entry_position = POS_W'($urandom_range(15));
            else if (sub < 85) b.entry_position = POS_W'($urandom_range(tracker.in_use - 1));
            else b.entry_position = POS_W'($urandom_range(511, tracker.in_use));
        end else if (pick < 87) begin
            b.mode = MODE_FIND;
            if (sub < 70) b.symbol_value = tracker.symbols[$urandom_range(tracker.in_use - 1)];
            else if (sub < 80) b.symbol_value = tracker.escape;
        end else if (pick < 97) begin
            b.mode = MODE_ADD;
        end else begin
            b.mode = MODE_RESTART;
        end
        return b;
    endfunction

    initial begin
        logic [SYM_W-1:0]   esc;
        logic [COUNT_W-1:0] lim;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        offer(MODE_FIND, 0, 0);
        offer(MODE_FIND, 0, -1);
        offer(MODE_FIND, 511, 16'h7FFF);
        offer(MODE_FIND, 0, 16'h8000);
        offer(MODE_ADD, 0, 16'h7FFF);
        offer(MODE_INC, 0, 0);
        offer(MODE_INC, 256, 16'hFFFF);
        offer(MODE_INC, 257, 0);
        offer(MODE_INC, 511, -1);
        offer(MODE_FIND, 0, -1);
        offer(MODE_INC, 256, 0);
        offer(MODE_INC, 128, 0);
        offer(MODE_INC, 128, 0);
        offer(MODE_FIND, 0, 255);
        offer(MODE_RESTART, 511, 16'h8000);
        offer(MODE_FIND, 0, -1);
        offer(MODE_ADD, 0, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            esc = (p == 3) ? SYM_W'($urandom) : PHASE_ESCAPE[p];
            lim = (p == 5) ? COUNT_W'($urandom_range(16383, 2)) : PHASE_LIMIT[p];
            write_reg(REG_ESCAPE, {16'h0000, esc});
            write_reg(REG_LIMIT, {18'h0, lim});
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            // The long receiver hold lets the output register fill so s_ready drops.
            if (p == 4) hold_requests++;
            offer(MODE_RESTART, 0, 0);
            for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
